### src/fb_dirty_range_to_rects_top_defines.svh
// Assertion macros shared by the dirty-range rectangle generator.
`ifndef FB_DIRTY_RANGE_TO_RECTS_TOP_DEFINES_SVH
`define FB_DIRTY_RANGE_TO_RECTS_TOP_DEFINES_SVH
`ifndef SYNTHESIS
// Generic form: explicit clock and active-low reset.
`define FBDR_ASSERT_CLK(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("fbdr assertion failed");
// Short form for modules clocked by clk_i and reset by rst_ni.
`define FBDR_ASSERT(lbl, prop) `FBDR_ASSERT_CLK(lbl, clk_i, rst_ni, prop)
`else
`define FBDR_ASSERT_CLK(lbl, clk, rst_n, prop)
`define FBDR_ASSERT(lbl, prop)
`endif
`endif

### src/fbdr_pkg.sv
// Shared types, widths, codes and helpers for the dirty-range rectangle generator.
`default_nettype none

package fbdr_pkg;

  // Store geometry
  localparam int PAGES           = 2;
  localparam int PAGE_W          = $clog2(PAGES);
  localparam int BYTES_PER_PIXEL = 4;
  localparam int BPP_SHIFT       = $clog2(BYTES_PER_PIXEL);
  localparam int BPP_DEPTH       = 32;

  // Field widths
  localparam int CMD_W      = 2;
  localparam int STAT_W     = 2;
  localparam int RES_W      = 13;
  localparam int PITCH_W    = 14;
  localparam int OFF_W      = 28;
  localparam int CNT_W      = 29;
  localparam int ARG_W      = 32;
  localparam int PB_BYTES_W = PITCH_W + BPP_SHIFT;       // pitch in bytes
  localparam int PAGEB_W    = PB_BYTES_W + RES_W;        // bytes per page
  localparam int TOT_W      = PAGEB_W + PAGE_W;          // bytes in whole store
  localparam int COL_W      = PB_BYTES_W + 1;            // byte column incl. end

  // Row divider: quotient is a row number below v_res
  localparam int DIV_STEPS  = RES_W;
  localparam int DIV_CNT_W  = $clog2(DIV_STEPS);

  // Config port
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = PITCH_W;
  localparam logic [CFG_IDX_W-1:0] CFG_H_RES = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_V_RES = CFG_IDX_W'(1);
  localparam logic [CFG_IDX_W-1:0] CFG_PITCH = CFG_IDX_W'(2);
  localparam logic [RES_W-1:0]   H_RES_RST = RES_W'(1024);
  localparam logic [RES_W-1:0]   V_RES_RST = RES_W'(768);
  localparam logic [PITCH_W-1:0] PITCH_RST = PITCH_W'(1024);

  // Commands and status codes
  localparam logic [CMD_W-1:0] CMD_WRITE = CMD_W'(0);
  localparam logic [CMD_W-1:0] CMD_SET   = CMD_W'(1);
  localparam logic [CMD_W-1:0] CMD_PAN   = CMD_W'(2);

  localparam logic [STAT_W-1:0] ST_OK      = STAT_W'(0);
  localparam logic [STAT_W-1:0] ST_INVAL   = STAT_W'(1);
  localparam logic [STAT_W-1:0] ST_UNKNOWN = STAT_W'(2);

  // Rectangle slots per item
  localparam int NUM_SLOTS  = 3;
  localparam int SLOT_IDX_W = $clog2(NUM_SLOTS);

  typedef struct packed {
    logic             valid;
    logic [RES_W-1:0] x1;
    logic [RES_W-1:0] y1;
    logic [RES_W-1:0] x2;
    logic [RES_W-1:0] y2;
  } rect_t;

  // Controller -> datapath
  typedef struct packed {
    logic                  load_in;
    logic                  mul;
    logic                  pre1;
    logic                  pre2;
    logic                  pre3;
    logic                  pre4;      // also loads divider with first-byte offset
    logic                  div_load2; // saves first quotient, loads last-byte offset
    logic                  div_step;
    logic                  build;
    logic                  out_load;
    logic                  out_empty;
    logic                  out_last;
    logic [SLOT_IDX_W-1:0] out_slot;
  } dp_ctl_t;

  // Datapath -> controller
  typedef struct packed {
    logic                 hit;
    logic [NUM_SLOTS-1:0] slot_valid;
    logic                 out_free;
  } dp_sts_t;

  // One partial scan line given as a byte span [bx1, bx2) of the row.
  function automatic rect_t byte_row(input logic [RES_W-1:0] row,
                                     input logic [COL_W-1:0] bx1,
                                     input logic [COL_W-1:0] bx2,
                                     input logic [RES_W-1:0] h_res);
    logic [COL_W-1:0] vis;
    logic [COL_W-1:0] b2;
    logic [COL_W-1:0] rnd;
    rect_t            r;
    vis     = COL_W'(h_res) << BPP_SHIFT;
    b2      = (bx2 < vis) ? bx2 : vis;
    rnd     = b2 + COL_W'(BYTES_PER_PIXEL - 1);
    r.valid = (bx1 < vis) && (bx1 < b2);
    r.x1    = bx1[BPP_SHIFT +: RES_W];
    r.x2    = rnd[BPP_SHIFT +: RES_W];
    r.y1    = row;
    r.y2    = row + RES_W'(1);
    return r;
  endfunction

endpackage

`default_nettype wire

### src/fbdr_ctrl.sv
// Sequencer: steps one command through setup, row division, build and emission.
`default_nettype none

module fbdr_ctrl (
  input  wire                clk_i,
  input  wire                rst_ni,
  input  wire                in_valid_i,
  output logic               in_ready_o,
  input  fbdr_pkg::dp_sts_t  sts_i,
  output fbdr_pkg::dp_ctl_t  ctl_o
);

`include "fb_dirty_range_to_rects_top_defines.svh"

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_MUL   = 4'd1;
  localparam logic [3:0] S_PRE1  = 4'd2;
  localparam logic [3:0] S_PRE2  = 4'd3;
  localparam logic [3:0] S_PRE3  = 4'd4;
  localparam logic [3:0] S_PRE4  = 4'd5;
  localparam logic [3:0] S_DIV1  = 4'd6;
  localparam logic [3:0] S_LOAD2 = 4'd7;
  localparam logic [3:0] S_DIV2  = 4'd8;
  localparam logic [3:0] S_BUILD = 4'd9;
  localparam logic [3:0] S_MASK  = 4'd10;
  localparam logic [3:0] S_EMIT  = 4'd11;

  logic [3:0]                         state_q, state_d;
  logic [fbdr_pkg::DIV_CNT_W-1:0]     cnt_q, cnt_d;
  logic [fbdr_pkg::NUM_SLOTS-1:0]     mask_q, mask_d;
  logic [fbdr_pkg::NUM_SLOTS-1:0]     rest;
  logic [fbdr_pkg::SLOT_IDX_W-1:0]    sel;
  logic                               cnt_end;

  assign cnt_end = (cnt_q == fbdr_pkg::DIV_CNT_W'(fbdr_pkg::DIV_STEPS - 1));

  // lowest pending slot first; clear lowest set bit
  always_comb begin
    sel = '0;
    for (int i = fbdr_pkg::NUM_SLOTS - 1; i >= 0; i--) begin
      if (mask_q[i]) sel = fbdr_pkg::SLOT_IDX_W'(i);
    end
  end
  assign rest = mask_q & (mask_q - fbdr_pkg::NUM_SLOTS'(1));

  always_comb begin
    state_d    = state_q;
    cnt_d      = cnt_q;
    mask_d     = mask_q;
    ctl_o      = '0;
    in_ready_o = 1'b0;
    case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          ctl_o.load_in = 1'b1;
          state_d       = S_MUL;
        end
      end
      S_MUL: begin
        ctl_o.mul = 1'b1;
        state_d   = S_PRE1;
      end
      S_PRE1: begin
        ctl_o.pre1 = 1'b1;
        state_d    = S_PRE2;
      end
      S_PRE2: begin
        ctl_o.pre2 = 1'b1;
        state_d    = S_PRE3;
      end
      S_PRE3: begin
        ctl_o.pre3 = 1'b1;
        state_d    = S_PRE4;
      end
      S_PRE4: begin
        ctl_o.pre4 = 1'b1;
        cnt_d      = '0;
        state_d    = S_DIV1;
      end
      S_DIV1: begin
        if (!sts_i.hit) begin
          state_d = S_BUILD;
        end else begin
          ctl_o.div_step = 1'b1;
          cnt_d          = cnt_q + fbdr_pkg::DIV_CNT_W'(1);
          if (cnt_end) state_d = S_LOAD2;
        end
      end
      S_LOAD2: begin
        ctl_o.div_load2 = 1'b1;
        cnt_d           = '0;
        state_d         = S_DIV2;
      end
      S_DIV2: begin
        ctl_o.div_step = 1'b1;
        cnt_d          = cnt_q + fbdr_pkg::DIV_CNT_W'(1);
        if (cnt_end) state_d = S_BUILD;
      end
      S_BUILD: begin
        ctl_o.build = 1'b1;
        state_d     = S_MASK;
      end
      S_MASK: begin
        mask_d  = sts_i.slot_valid;
        state_d = S_EMIT;
      end
      S_EMIT: begin
        if (sts_i.out_free) begin
          ctl_o.out_load = 1'b1;
          if (mask_q == '0) begin
            ctl_o.out_empty = 1'b1;
            ctl_o.out_last  = 1'b1;
            state_d         = S_IDLE;
          end else begin
            ctl_o.out_slot = sel;
            ctl_o.out_last = (rest == '0);
            mask_d         = rest;
            if (rest == '0) state_d = S_IDLE;
          end
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      cnt_q   <= '0;
      mask_q  <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      mask_q  <= mask_d;
    end
  end

  `FBDR_ASSERT(a_accept_busy, (in_valid_i && in_ready_o) |=> !in_ready_o)
  `FBDR_ASSERT(a_div_cnt_range, (state_q == S_DIV2) |-> (cnt_q <= fbdr_pkg::DIV_CNT_W'(fbdr_pkg::DIV_STEPS - 1)))
  `FBDR_ASSERT(a_mask_only_emit, (state_q != S_EMIT) |-> (mask_q == '0))

endmodule

`default_nettype wire

### src/fbdr_dp.sv
// Datapath: config, page arithmetic, shared row divider, rectangle slots, output register.
`default_nettype none

module fbdr_dp (
  input  wire                                 clk_i,
  input  wire                                 rst_ni,
  input  wire                                 cfg_we_i,
  input  wire  [fbdr_pkg::CFG_IDX_W-1:0]      cfg_index_i,
  input  wire  [fbdr_pkg::CFG_DATA_W-1:0]     cfg_data_i,
  input  wire  [fbdr_pkg::CMD_W-1:0]          cmd_i,
  input  wire  [fbdr_pkg::OFF_W-1:0]          byte_offset_i,
  input  wire  [fbdr_pkg::CNT_W-1:0]          byte_count_i,
  input  wire  [fbdr_pkg::ARG_W-1:0]          y_offset_i,
  input  wire  [fbdr_pkg::ARG_W-1:0]          x_offset_i,
  input  wire  [fbdr_pkg::ARG_W-1:0]          bits_per_pixel_i,
  input  fbdr_pkg::dp_ctl_t                   ctl_i,
  output fbdr_pkg::dp_sts_t                   sts_o,
  input  wire                                 out_ready_i,
  output logic                                out_valid_o,
  output logic [fbdr_pkg::STAT_W-1:0]         status_o,
  output logic [fbdr_pkg::CNT_W-1:0]          accepted_bytes_o,
  output logic                                shown_page_o,
  output logic                                rect_valid_o,
  output logic                                rect_page_o,
  output logic [fbdr_pkg::RES_W-1:0]          x_start_o,
  output logic [fbdr_pkg::RES_W-1:0]          y_start_o,
  output logic [fbdr_pkg::RES_W-1:0]          x_end_o,
  output logic [fbdr_pkg::RES_W-1:0]          y_end_o,
  output logic                                last_o
);

`include "fb_dirty_range_to_rects_top_defines.svh"

  localparam int RES_W   = fbdr_pkg::RES_W;
  localparam int PAGEB_W = fbdr_pkg::PAGEB_W;
  localparam int TOT_W   = fbdr_pkg::TOT_W;
  localparam int ARG_W   = fbdr_pkg::ARG_W;
  localparam int PAGE_W  = fbdr_pkg::PAGE_W;
  localparam int COL_W   = fbdr_pkg::COL_W;
  localparam int PBB_W   = fbdr_pkg::PB_BYTES_W;

  // config and page state
  logic [RES_W-1:0]              h_res_q, v_res_q;
  logic [fbdr_pkg::PITCH_W-1:0]  pitch_q;
  logic [PAGE_W-1:0]             shown_q;

  // captured item
  logic [fbdr_pkg::CMD_W-1:0]    cmd_q;
  logic [fbdr_pkg::OFF_W-1:0]    boff_q;
  logic [fbdr_pkg::CNT_W-1:0]    bcnt_q;
  logic [ARG_W-1:0]              yoff_q, xoff_q, bpp_q;

  // setup pipeline
  logic [PBB_W-1:0]              pbytes;
  logic [PAGEB_W-1:0]            page_q, page_d;
  logic [TOT_W-1:0]              total_q, total_d, as_q, as_d, ae_q, ae_d, end_q, end_d;
  logic [TOT_W-1:0]              boff_ext, room, ds, de;
  logic [ARG_W-1:0]              vres_pages;
  logic                          arg_bad, bad_q, bad_d, in_store;
  logic [PAGE_W-1:0]             newpage_q, newpage_d;
  logic [fbdr_pkg::CNT_W-1:0]    accepted_q, accepted_d;
  logic                          below_q, nz_q, hit_q, hit_d;
  logic [PAGEB_W-1:0]            off_d, lastb_q, lastb_d;
  logic                          is_setpan;

  // row divider
  logic [PAGEB_W-1:0]            rem_q, dsr_q, dsr_init;
  logic [RES_W-1:0]              quo_q;
  logic                          ge;
  logic [RES_W-1:0]              rs_q;
  logic [PBB_W-1:0]              sx_q;

  // rectangle slots
  fbdr_pkg::rect_t               slot_q [fbdr_pkg::NUM_SLOTS];
  fbdr_pkg::rect_t               slot_d [fbdr_pkg::NUM_SLOTS];
  logic [fbdr_pkg::STAT_W-1:0]   status_q, status_d;
  logic [COL_W-1:0]              ex, sx_ext, pb_ext;
  logic [RES_W:0]                rs1;
  fbdr_pkg::rect_t               pick;

  assign pbytes   = PBB_W'(pitch_q) << fbdr_pkg::BPP_SHIFT;
  assign boff_ext = TOT_W'(boff_q);
  assign is_setpan = (cmd_q == fbdr_pkg::CMD_SET) || (cmd_q == fbdr_pkg::CMD_PAN);

  // ---- config and shown page
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      h_res_q <= fbdr_pkg::H_RES_RST;
      v_res_q <= fbdr_pkg::V_RES_RST;
      pitch_q <= fbdr_pkg::PITCH_RST;
      shown_q <= '0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_index_i)
          fbdr_pkg::CFG_H_RES: h_res_q <= cfg_data_i[RES_W-1:0];
          fbdr_pkg::CFG_V_RES: v_res_q <= cfg_data_i[RES_W-1:0];
          fbdr_pkg::CFG_PITCH: pitch_q <= cfg_data_i[fbdr_pkg::PITCH_W-1:0];
          default: ;
        endcase
      end
      if (ctl_i.build && is_setpan && !bad_q) shown_q <= newpage_q;
    end
  end

  // ---- setup arithmetic
  assign page_d = PAGEB_W'(pbytes) * PAGEB_W'(v_res_q);

  always_comb begin
    total_d    = TOT_W'(page_q) * TOT_W'(fbdr_pkg::PAGES);
    as_d       = TOT_W'(page_q) * TOT_W'(shown_q);
    vres_pages = ARG_W'(v_res_q) * ARG_W'(fbdr_pkg::PAGES);
    arg_bad    = (cmd_q == fbdr_pkg::CMD_SET) ?
                 ((bpp_q != '0) && (bpp_q != ARG_W'(fbdr_pkg::BPP_DEPTH))) :
                 (xoff_q != '0);
    bad_d      = arg_bad || (v_res_q == '0) || (yoff_q >= vres_pages);
    newpage_d  = '0;
    for (int k = 1; k < fbdr_pkg::PAGES; k++) begin
      if (yoff_q >= ARG_W'(v_res_q) * ARG_W'(k)) newpage_d = PAGE_W'(k);
    end
  end

  always_comb begin
    in_store   = boff_ext < total_q;
    room       = total_q - boff_ext;
    ae_d       = as_q + TOT_W'(page_q);
    accepted_d = '0;
    if ((cmd_q == fbdr_pkg::CMD_WRITE) && in_store) begin
      accepted_d = (TOT_W'(bcnt_q) < room) ? bcnt_q : fbdr_pkg::CNT_W'(room);
    end
    end_d   = boff_ext + TOT_W'(accepted_q);
    hit_d   = below_q && nz_q && (end_q > as_q);
    ds      = (boff_ext > as_q) ? boff_ext : as_q;
    de      = (end_q < ae_q) ? end_q : ae_q;
    off_d   = PAGEB_W'(ds - as_q);
    lastb_d = PAGEB_W'(de - as_q - TOT_W'(1));
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.load_in) begin
      cmd_q  <= cmd_i;
      boff_q <= byte_offset_i;
      bcnt_q <= byte_count_i;
      yoff_q <= y_offset_i;
      xoff_q <= x_offset_i;
      bpp_q  <= bits_per_pixel_i;
    end
    if (ctl_i.mul) page_q <= page_d;
    if (ctl_i.pre1) begin
      total_q   <= total_d;
      as_q      <= as_d;
      bad_q     <= bad_d;
      newpage_q <= newpage_d;
    end
    if (ctl_i.pre2) begin
      ae_q       <= ae_d;
      accepted_q <= accepted_d;
    end
    if (ctl_i.pre3) begin
      end_q   <= end_d;
      below_q <= boff_ext < ae_q;
      nz_q    <= accepted_q != '0;
    end
    if (ctl_i.pre4) lastb_q <= lastb_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hit_q <= 1'b0;
    end else if (ctl_i.pre4) begin
      hit_q <= hit_d;
    end
  end

  // ---- restoring divider by pitch bytes, one quotient bit per step
  assign dsr_init = PAGEB_W'(pbytes) << (fbdr_pkg::DIV_STEPS - 1);
  assign ge       = rem_q >= dsr_q;

  always_ff @(posedge clk_i) begin
    if (ctl_i.pre4) begin
      rem_q <= off_d;
      dsr_q <= dsr_init;
      quo_q <= '0;
    end else if (ctl_i.div_load2) begin
      rs_q  <= quo_q;
      sx_q  <= rem_q[PBB_W-1:0];
      rem_q <= lastb_q;
      dsr_q <= dsr_init;
      quo_q <= '0;
    end else if (ctl_i.div_step) begin
      rem_q <= ge ? (rem_q - dsr_q) : rem_q;
      quo_q <= {quo_q[RES_W-2:0], ge};
      dsr_q <= dsr_q >> 1;
    end
  end

  // ---- rectangle build: quo_q/rem_q now hold last row and its column
  always_comb begin
    ex     = COL_W'(rem_q[PBB_W-1:0]) + COL_W'(1);
    sx_ext = COL_W'(sx_q);
    pb_ext = COL_W'(pbytes);
    rs1    = {1'b0, rs_q} + (RES_W + 1)'(1);
    for (int i = 0; i < fbdr_pkg::NUM_SLOTS; i++) slot_d[i] = '0;
    status_d = fbdr_pkg::ST_UNKNOWN;
    case (cmd_q)
      fbdr_pkg::CMD_WRITE: status_d = fbdr_pkg::ST_OK;
      fbdr_pkg::CMD_SET,
      fbdr_pkg::CMD_PAN:   status_d = bad_q ? fbdr_pkg::ST_INVAL : fbdr_pkg::ST_OK;
      default:             status_d = fbdr_pkg::ST_UNKNOWN;
    endcase
    if (hit_q) begin
      if (rs_q == quo_q) begin
        slot_d[0] = fbdr_pkg::byte_row(rs_q, sx_ext, ex, h_res_q);
      end else begin
        slot_d[0]       = fbdr_pkg::byte_row(rs_q, sx_ext, pb_ext, h_res_q);
        slot_d[1].valid = (rs1 < {1'b0, quo_q}) && (h_res_q != '0);
        slot_d[1].x1    = '0;
        slot_d[1].y1    = rs1[RES_W-1:0];
        slot_d[1].x2    = h_res_q;
        slot_d[1].y2    = quo_q;
        slot_d[2]       = fbdr_pkg::byte_row(quo_q, '0, ex, h_res_q);
      end
    end else if (is_setpan && !bad_q) begin
      slot_d[0].valid = h_res_q != '0;
      slot_d[0].x1    = '0;
      slot_d[0].y1    = '0;
      slot_d[0].x2    = h_res_q;
      slot_d[0].y2    = v_res_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.build) begin
      status_q <= status_d;
      for (int i = 0; i < fbdr_pkg::NUM_SLOTS; i++) slot_q[i] <= slot_d[i];
    end
  end

  always_comb begin
    for (int i = 0; i < fbdr_pkg::NUM_SLOTS; i++) sts_o.slot_valid[i] = slot_q[i].valid;
  end
  assign sts_o.hit      = hit_q;
  assign sts_o.out_free = !out_valid_o || out_ready_i;

  // ---- output register
  assign pick = slot_q[ctl_i.out_slot];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_o <= 1'b0;
    end else if (ctl_i.out_load) begin
      out_valid_o <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_o <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.out_load) begin
      status_o         <= status_q;
      accepted_bytes_o <= accepted_q;
      shown_page_o     <= shown_q[0];
      last_o           <= ctl_i.out_last;
      if (ctl_i.out_empty) begin
        rect_valid_o <= 1'b0;
        rect_page_o  <= 1'b0;
        x_start_o    <= '0;
        y_start_o    <= '0;
        x_end_o      <= '0;
        y_end_o      <= '0;
      end else begin
        rect_valid_o <= 1'b1;
        rect_page_o  <= shown_q[0];
        x_start_o    <= pick.x1;
        y_start_o    <= pick.y1;
        x_end_o      <= pick.x2;
        y_end_o      <= pick.y2;
      end
    end
  end

  `FBDR_ASSERT(a_page_range, {1'b0, shown_q} < (PAGE_W + 1)'(fbdr_pkg::PAGES))
  `FBDR_ASSERT(a_rows_ordered, (ctl_i.build && hit_q) |-> (rs_q <= quo_q))

endmodule

`default_nettype wire

### src/fb_dirty_range_to_rects_top.sv
// Top level of the framebuffer dirty-range to present-rectangle generator.
//
//   channel  dir  handshake               payload
//   -------  ---  ----------------------  ---------------------------------------------
//   in       in   in_valid_i/in_ready_o   cmd, byte_offset, byte_count, y/x_offset, bpp
//   out      out  out_valid_o/out_ready_i status, accepted_bytes, shown_page, rect, last
//   cfg      in   cfg_we_i (no wait)      cfg_index_i, cfg_data_i (h_res, v_res, pitch)
//
// Timing: one item at a time. A write whose range hits the shown page runs the
//   shared restoring divider, 13 steps for the first row/column and 13 for the
//   last, and then emits one to three results; other commands skip the divider.
//   Back-pressure on out stretches the emit phase only.
// Reset: asynchronous, active low; restores h_res 1024, v_res 768, pitch 1024,
//   page 0 shown, output empty.
// The output register decouples the sides: the next item is taken while the last
//   result of the previous one still waits on out.
`default_nettype none

module fb_dirty_range_to_rects_top (
  input  wire                             clk_i,
  input  wire                             rst_ni,
  // config write port
  input  wire                             cfg_we_i,
  input  wire  [fbdr_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  wire  [fbdr_pkg::CFG_DATA_W-1:0] cfg_data_i,
  // command items
  input  wire                             in_valid_i,
  output logic                            in_ready_o,
  input  wire  [fbdr_pkg::CMD_W-1:0]      cmd_i,
  input  wire  [fbdr_pkg::OFF_W-1:0]      byte_offset_i,
  input  wire  [fbdr_pkg::CNT_W-1:0]      byte_count_i,
  input  wire  [fbdr_pkg::ARG_W-1:0]      y_offset_i,
  input  wire  [fbdr_pkg::ARG_W-1:0]      x_offset_i,
  input  wire  [fbdr_pkg::ARG_W-1:0]      bits_per_pixel_i,
  // result items
  output logic                            out_valid_o,
  input  wire                             out_ready_i,
  output logic [fbdr_pkg::STAT_W-1:0]     status_o,
  output logic [fbdr_pkg::CNT_W-1:0]      accepted_bytes_o,
  output logic                            shown_page_o,
  output logic                            rect_valid_o,
  output logic                            rect_page_o,
  output logic [fbdr_pkg::RES_W-1:0]      x_start_o,
  output logic [fbdr_pkg::RES_W-1:0]      y_start_o,
  output logic [fbdr_pkg::RES_W-1:0]      x_end_o,
  output logic [fbdr_pkg::RES_W-1:0]      y_end_o,
  output logic                            last_o
);

  fbdr_pkg::dp_ctl_t ctl;
  fbdr_pkg::dp_sts_t sts;

  // Controller: idle -> page multiply -> four setup steps (store bounds, accepted
  // bytes, page intersection, in-page offsets) -> row divisions -> build -> mask -> emit.
  fbdr_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .sts_i      (sts),
    .ctl_o      (ctl)
  );

  // Datapath: config registers, shown page, setup arithmetic, divider, the three
  // rectangle slots (first partial row, middle block, last partial row) and the
  // output register.
  fbdr_dp u_dp (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_we_i         (cfg_we_i),
    .cfg_index_i      (cfg_index_i),
    .cfg_data_i       (cfg_data_i),
    .cmd_i            (cmd_i),
    .byte_offset_i    (byte_offset_i),
    .byte_count_i     (byte_count_i),
    .y_offset_i       (y_offset_i),
    .x_offset_i       (x_offset_i),
    .bits_per_pixel_i (bits_per_pixel_i),
    .ctl_i            (ctl),
    .sts_o            (sts),
    .out_ready_i      (out_ready_i),
    .out_valid_o      (out_valid_o),
    .status_o         (status_o),
    .accepted_bytes_o (accepted_bytes_o),
    .shown_page_o     (shown_page_o),
    .rect_valid_o     (rect_valid_o),
    .rect_page_o      (rect_page_o),
    .x_start_o        (x_start_o),
    .y_start_o        (y_start_o),
    .x_end_o          (x_end_o),
    .y_end_o          (y_end_o),
    .last_o           (last_o)
  );

endmodule

`default_nettype wire

### tb/tb.sv
// Self-checking testbench for the framebuffer dirty-range to present-rectangle generator.
`timescale 1ns / 1ps

module tb;
  import fbdr_pkg::*;

  // cmd 3 has no name in the package; the block must answer it as unknown
  localparam logic [CMD_W-1:0] CMD_UNKNOWN = CMD_W'(3);

  localparam int              MAX_BOXES     = 3;     // rectangles per write at most
  localparam int              SETTLE_CYCLES = 60;    // idle wait once every result is in
  localparam int              QUIET_LIMIT   = 3000;  // cycles with no handshake at all
  localparam longint unsigned COUNT_MAX     = 64'd1 << OFF_W;
  localparam longint unsigned PIX_BYTES     = BYTES_PER_PIXEL;

  typedef enum {RX_FREE, RX_CHOPPY, RX_SLOW} rx_mode_t;

  // one command item as driven on the input channel
  typedef struct {
    logic [CMD_W-1:0] cmd;
    logic [OFF_W-1:0] byte_offset;
    logic [CNT_W-1:0] byte_count;
    logic [ARG_W-1:0] y_offset;
    logic [ARG_W-1:0] x_offset;
    logic [ARG_W-1:0] bits_per_pixel;
  } fb_cmd_t;

  // one result item as seen on the output channel
  typedef struct {
    logic [STAT_W-1:0] status;
    logic [CNT_W-1:0]  accepted_bytes;
    logic              shown_page;
    logic              rect_valid;
    logic              rect_page;
    logic [RES_W-1:0]  x_start;
    logic [RES_W-1:0]  y_start;
    logic [RES_W-1:0]  x_end;
    logic [RES_W-1:0]  y_end;
    logic              last;
  } present_t;

  typedef struct {
    longint unsigned x1, y1, x2, y2;
  } dirty_box_t;

  // ---------------------------------------------------------------------------
  // DUT hookup
  // ---------------------------------------------------------------------------
  logic                  clk_i;
  logic                  rst_ni;
  logic                  cfg_we_i;
  logic [CFG_IDX_W-1:0]  cfg_index_i;
  logic [CFG_DATA_W-1:0] cfg_data_i;
  logic                  in_valid_i;
  logic                  in_ready_o;
  logic [CMD_W-1:0]      cmd_i;
  logic [OFF_W-1:0]      byte_offset_i;
  logic [CNT_W-1:0]      byte_count_i;
  logic [ARG_W-1:0]      y_offset_i;
  logic [ARG_W-1:0]      x_offset_i;
  logic [ARG_W-1:0]      bits_per_pixel_i;
  logic                  out_valid_o;
  logic                  out_ready_i = 1'b0;
  logic [STAT_W-1:0]     status_o;
  logic [CNT_W-1:0]      accepted_bytes_o;
  logic                  shown_page_o;
  logic                  rect_valid_o;
  logic                  rect_page_o;
  logic [RES_W-1:0]      x_start_o;
  logic [RES_W-1:0]      y_start_o;
  logic [RES_W-1:0]      x_end_o;
  logic [RES_W-1:0]      y_end_o;
  logic                  last_o;

  fb_dirty_range_to_rects_top DUT (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_we_i         (cfg_we_i),
    .cfg_index_i      (cfg_index_i),
    .cfg_data_i       (cfg_data_i),
    .in_valid_i       (in_valid_i),
    .in_ready_o       (in_ready_o),
    .cmd_i            (cmd_i),
    .byte_offset_i    (byte_offset_i),
    .byte_count_i     (byte_count_i),
    .y_offset_i       (y_offset_i),
    .x_offset_i       (x_offset_i),
    .bits_per_pixel_i (bits_per_pixel_i),
    .out_valid_o      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .status_o         (status_o),
    .accepted_bytes_o (accepted_bytes_o),
    .shown_page_o     (shown_page_o),
    .rect_valid_o     (rect_valid_o),
    .rect_page_o      (rect_page_o),
    .x_start_o        (x_start_o),
    .y_start_o        (y_start_o),
    .x_end_o          (x_end_o),
    .y_end_o          (y_end_o),
    .last_o           (last_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // ---------------------------------------------------------------------------
  // Rectangle predictor: own copy of the registers and the shown page
  // ---------------------------------------------------------------------------
  logic [RES_W-1:0]   geo_h_res = RES_W'(1024);
  logic [RES_W-1:0]   geo_v_res = RES_W'(768);
  logic [PITCH_W-1:0] geo_pitch = PITCH_W'(1024);
  int unsigned        shown_page_q = 0;

  dirty_box_t  dirty_boxes[$];      // rectangles of the item being predicted
  present_t    pending_results[$];  // results still owed by the block
  int unsigned mismatches = 0;

  // Clip to the visible area; empty boxes are dropped, at most three kept.
  function automatic void add_box(longint unsigned x1, longint unsigned y1,
                                  longint unsigned x2, longint unsigned y2);
    dirty_box_t b;
    if (x1 > geo_h_res) x1 = geo_h_res;
    if (x2 > geo_h_res) x2 = geo_h_res;
    if (y1 > geo_v_res) y1 = geo_v_res;
    if (y2 > geo_v_res) y2 = geo_v_res;
    if (x1 >= x2 || y1 >= y2 || dirty_boxes.size() >= MAX_BOXES) return;
    b.x1 = x1;
    b.y1 = y1;
    b.x2 = x2;
    b.y2 = y2;
    dirty_boxes.push_back(b);
  endfunction

  // Byte span [bx1, bx2) of one scan line; end pixel rounded up.
  function automatic void add_row(longint unsigned row, longint unsigned bx1,
                                  longint unsigned bx2);
    longint unsigned vis;
    vis = PIX_BYTES * geo_h_res;
    if (row >= geo_v_res || bx1 >= vis) return;
    if (bx2 > vis) bx2 = vis;
    if (bx1 >= bx2) return;
    add_box(bx1 / PIX_BYTES, row, (bx2 + PIX_BYTES - 1) / PIX_BYTES, row + 1);
  endfunction

  // Dirty span within the shown page: first row, middle block, last row.
  function automatic void add_page_span(longint unsigned page_bytes, longint unsigned off,
                                        longint unsigned n);
    longint unsigned line_bytes, span_end, room, rs, re, sx, ex;
    line_bytes = PIX_BYTES * geo_pitch;
    if (n == 0 || off >= page_bytes || line_bytes == 0) return;
    room     = page_bytes - off;
    span_end = off + ((n < room) ? n : room);
    rs = off / line_bytes;
    re = (span_end - 1) / line_bytes;
    if (rs >= geo_v_res) return;
    if (re >= geo_v_res) re = geo_v_res - 1;
    sx = off % line_bytes;
    ex = ((span_end - 1) % line_bytes) + 1;
    if (rs == re) begin
      add_row(rs, sx, ex);
      return;
    end
    add_row(rs, sx, line_bytes);
    if (rs + 1 < re) add_box(0, rs + 1, geo_h_res, re);
    add_row(re, 0, ex);
  endfunction

  // Work out every result that one accepted command item must produce.
  function automatic void predict_results(fb_cmd_t c);
    longint unsigned   page_bytes, store_bytes, room, accepted, wr_end;
    longint unsigned   win_lo, win_hi, span_lo, span_hi, rows_all;
    logic [STAT_W-1:0] status;
    bit                bad;
    int                n;
    present_t          r;
    dirty_boxes.delete();
    status   = ST_OK;
    accepted = 0;
    if (c.cmd == CMD_WRITE) begin
      page_bytes  = PIX_BYTES * geo_pitch * geo_v_res;
      store_bytes = page_bytes * PAGES;
      if (c.byte_offset < store_bytes) begin
        room     = store_bytes - c.byte_offset;
        accepted = (c.byte_count < room) ? c.byte_count : room;
        wr_end   = c.byte_offset + accepted;
        win_lo   = shown_page_q * page_bytes;
        win_hi   = win_lo + page_bytes;
        if (c.byte_offset < win_hi && wr_end > win_lo) begin
          span_lo = (c.byte_offset > win_lo) ? c.byte_offset : win_lo;
          span_hi = (wr_end < win_hi) ? wr_end : win_hi;
          add_page_span(page_bytes, span_lo - win_lo, span_hi - span_lo);
        end
      end
    end else if (c.cmd == CMD_SET || c.cmd == CMD_PAN) begin
      if (c.cmd == CMD_SET) bad = (c.bits_per_pixel != 0) && (c.bits_per_pixel != BPP_DEPTH);
      else bad = (c.x_offset != 0);
      rows_all = geo_v_res;
      rows_all = rows_all * PAGES;
      if (!bad && (geo_v_res == 0 || c.y_offset >= rows_all)) bad = 1'b1;
      if (bad) begin
        status = ST_INVAL;
      end else begin
        shown_page_q = c.y_offset / geo_v_res;
        add_box(0, 0, geo_h_res, geo_v_res);
      end
    end else begin
      status = ST_UNKNOWN;
    end

    n = (dirty_boxes.size() > 0) ? dirty_boxes.size() : 1;
    for (int k = 0; k < n; k++) begin
      r = '{default: '0};
      r.status         = status;
      r.accepted_bytes = CNT_W'(accepted);
      r.shown_page     = shown_page_q[0];
      r.last           = (k == n - 1);
      if (k < dirty_boxes.size()) begin
        r.rect_valid = 1'b1;
        r.rect_page  = shown_page_q[0];
        r.x_start    = RES_W'(dirty_boxes[k].x1);
        r.y_start    = RES_W'(dirty_boxes[k].y1);
        r.x_end      = RES_W'(dirty_boxes[k].x2);
        r.y_end      = RES_W'(dirty_boxes[k].y2);
      end
      pending_results.push_back(r);
    end
  endfunction

  // ---------------------------------------------------------------------------
  // Result checker: every output handshake is matched against the oldest entry
  // ---------------------------------------------------------------------------
  function automatic void check_field(string name, logic [63:0] want, logic [63:0] got);
    if (want !== got) begin
      mismatches++;
      $display("%0t: %s mismatch: expected %0d, actual %0d", $time, name, want, got);
    end
  endfunction

  always @(posedge clk_i) begin
    present_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (pending_results.size() == 0) begin
        mismatches++;
        $display("%0t: unexpected result: status %0d rect %0d (%0d,%0d)-(%0d,%0d) last %0d",
                 $time, status_o, rect_valid_o, x_start_o, y_start_o, x_end_o, y_end_o,
                 last_o);
      end else begin
        want = pending_results.pop_front();
        check_field("status", want.status, status_o);
        check_field("accepted_bytes", want.accepted_bytes, accepted_bytes_o);
        check_field("shown_page", want.shown_page, shown_page_o);
        check_field("rect_valid", want.rect_valid, rect_valid_o);
        check_field("rect_page", want.rect_page, rect_page_o);
        check_field("x_start", want.x_start, x_start_o);
        check_field("y_start", want.y_start, y_start_o);
        check_field("x_end", want.x_end, x_end_o);
        check_field("y_end", want.y_end, y_end_o);
        check_field("last", want.last, last_o);
      end
    end
  end

  // Watchdog: a hung handshake on either side ends the run.
  int unsigned quiet_cycles = 0;

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) quiet_cycles = 0;
      else quiet_cycles++;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("%0t: no item moved for %0d cycles", $time, QUIET_LIMIT);
        $display("RESULT: ERROR");
        $finish;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Receiver: runs of ready and stalled cycles; length depends on the mode
  // ---------------------------------------------------------------------------
  rx_mode_t rx_mode = RX_FREE;
  bit       rx_open = 1'b0;
  int       rx_run  = 0;

  always @(negedge clk_i) begin
    if (rx_run == 0) begin
      rx_open = !rx_open;
      case (rx_mode)
        RX_CHOPPY: rx_run = rx_open ? $urandom_range(1, 6) : $urandom_range(1, 3);
        RX_SLOW:   rx_run = rx_open ? $urandom_range(1, 4) : $urandom_range(5, 25);
        default:   rx_run = 8;
      endcase
    end
    rx_run--;
    out_ready_i <= (rx_mode == RX_FREE) || rx_open;
  end

  // ---------------------------------------------------------------------------
  // Sender: items go out in bursts; a gap of up to tx_gap_max cycles between
  // bursts (none when zero). Every call starts and ends at a falling edge.
  // ---------------------------------------------------------------------------
  int tx_gap_max = 0;
  int tx_burst   = 0;

  task automatic send_cmd(input fb_cmd_t c);
    if (tx_burst == 0) begin
      tx_burst = $urandom_range(1, 6);
      if (tx_gap_max > 0) begin
        in_valid_i <= 1'b0;
        repeat ($urandom_range(1, tx_gap_max)) @(negedge clk_i);
      end
    end
    tx_burst--;
    in_valid_i       <= 1'b1;
    cmd_i            <= c.cmd;
    byte_offset_i    <= c.byte_offset;
    byte_count_i     <= c.byte_count;
    y_offset_i       <= c.y_offset;
    x_offset_i       <= c.x_offset;
    bits_per_pixel_i <= c.bits_per_pixel;
    do @(posedge clk_i); while (!in_ready_o);
    predict_results(c);
    @(negedge clk_i);
  endtask

  // Drop valid and wait until the block has nothing left to deliver.
  task automatic settle();
    in_valid_i <= 1'b0;
    tx_burst = 0;
    while (pending_results.size() != 0) @(negedge clk_i);
    repeat (SETTLE_CYCLES) @(negedge clk_i);
  endtask

  // Register writes only happen with the block idle.
  task automatic set_geometry(int unsigned h, int unsigned v, int unsigned p);
    settle();
    cfg_we_i    <= 1'b1;
    cfg_index_i <= CFG_H_RES;
    cfg_data_i  <= CFG_DATA_W'(h);
    @(negedge clk_i);
    cfg_index_i <= CFG_V_RES;
    cfg_data_i  <= CFG_DATA_W'(v);
    @(negedge clk_i);
    cfg_index_i <= CFG_PITCH;
    cfg_data_i  <= CFG_DATA_W'(p);
    @(negedge clk_i);
    cfg_we_i  <= 1'b0;
    geo_h_res = RES_W'(h);
    geo_v_res = RES_W'(v);
    geo_pitch = PITCH_W'(p);
  endtask

  // ---------------------------------------------------------------------------
  // Item builders; fields the command ignores carry random values
  // ---------------------------------------------------------------------------
  function automatic fb_cmd_t write_cmd(longint unsigned off, longint unsigned cnt);
    fb_cmd_t c;
    c.cmd            = CMD_WRITE;
    c.byte_offset    = OFF_W'(off);
    c.byte_count     = CNT_W'(cnt);
    c.y_offset       = $urandom();
    c.x_offset       = $urandom();
    c.bits_per_pixel = $urandom();
    return c;
  endfunction

  function automatic fb_cmd_t screen_cmd(logic [CMD_W-1:0] op, longint unsigned y,
                                         longint unsigned x, longint unsigned bpp);
    fb_cmd_t c;
    c.cmd            = op;
    c.byte_offset    = OFF_W'($urandom());
    c.byte_count     = CNT_W'($urandom_range(0, COUNT_MAX));
    c.y_offset       = ARG_W'(y);
    c.x_offset       = ARG_W'(x);
    c.bits_per_pixel = ARG_W'(bpp);
    return c;
  endfunction

  // Well-formed write: a spot inside the store, mostly on the shown page,
  // with a length from a few bytes up to past the end of the store.
  function automatic fb_cmd_t rand_write();
    longint unsigned line_bytes, page_bytes, page, row, col, cnt;
    line_bytes = PIX_BYTES * geo_pitch;
    page_bytes = line_bytes * geo_v_res;
    if (page_bytes == 0) return write_cmd($urandom_range(0, 4096), $urandom_range(0, 4096));
    page = ($urandom_range(0, 3) == 0) ? $urandom_range(0, PAGES - 1) : shown_page_q;
    row  = $urandom_range(0, geo_v_res - 1);
    col  = $urandom_range(0, line_bytes - 1);
    if ($urandom_range(0, 1)) col = col & ~64'd3;
    case ($urandom_range(0, 4))
      0:       cnt = $urandom_range(1, 16);
      1:       cnt = $urandom_range(1, line_bytes);
      2:       cnt = $urandom_range(line_bytes, 4 * line_bytes);
      3:       cnt = $urandom_range(1, page_bytes);
      default: cnt = $urandom_range(page_bytes, COUNT_MAX);
    endcase
    return write_cmd(page * page_bytes + row * line_bytes + col, cnt);
  endfunction

  function automatic fb_cmd_t rand_item();
    int unsigned     pick;
    longint unsigned y_ok;
    pick = $urandom_range(0, 99);
    y_ok = (geo_v_res != 0) ? $urandom_range(0, 2 * geo_v_res - 1) : $urandom();
    if (pick < 60) return rand_write();
    if (pick < 68) return write_cmd($urandom(), $urandom_range(0, COUNT_MAX));
    if (pick < 80)
      return screen_cmd(CMD_SET, y_ok, $urandom(),
                        ($urandom_range(0, 3) == 0) ? $urandom() :
                        ($urandom_range(0, 1) ? BPP_DEPTH : 0));
    if (pick < 92)
      return screen_cmd(CMD_PAN, y_ok, ($urandom_range(0, 4) == 0) ? $urandom() : 0,
                        $urandom());
    if (pick < 96)
      return screen_cmd($urandom_range(0, 1) ? CMD_SET : CMD_PAN, $urandom(), 0, 0);
    return screen_cmd(CMD_UNKNOWN, $urandom(), $urandom(), $urandom());
  endfunction

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Geometry straight out of reset: 1024x768, pitch 1024, page 0 shown.
  // One page is 0x300000 bytes, the store 0x600000.
  task automatic test_reset_defaults();
    tx_gap_max = 4;
    rx_mode    = RX_CHOPPY;
    send_cmd(write_cmd(0, 4));                        // one pixel
    send_cmd(write_cmd(2, 3));                        // unaligned, end rounded up
    send_cmd(write_cmd(4000, 200));                   // tail of row 0, head of row 1
    send_cmd(write_cmd(0, 'h300000));                 // whole page: all three parts
    send_cmd(write_cmd('h300000, 64));                // hidden page: bytes but no rect
    send_cmd(write_cmd('h5FFFF0, COUNT_MAX));         // clipped at the store end
    send_cmd(write_cmd((64'd1 << OFF_W) - 1, COUNT_MAX));  // past the store
    send_cmd(write_cmd(8, 0));                        // zero count
    send_cmd(screen_cmd(CMD_SET, 768, $urandom(), BPP_DEPTH));      // show page 1
    send_cmd(write_cmd('h300000 + 4096 * 5 + 8, 4096 * 3));
    send_cmd(screen_cmd(CMD_SET, 1536, $urandom(), 0));             // offset too large
    send_cmd(screen_cmd(CMD_SET, 0, $urandom(), 16));               // depth refused
    send_cmd(screen_cmd(CMD_PAN, 767, 0, $urandom()));              // back to page 0
    send_cmd(screen_cmd(CMD_PAN, 0, 1, $urandom()));                // x offset refused
    send_cmd(screen_cmd(CMD_PAN, '1, '1, '1));
    send_cmd(screen_cmd(CMD_UNKNOWN, '1, '1, '1));
  endtask

  // One-pixel geometry, a 4096x4096 screen with pitch 8192, and a pitch wider than the screen.
  task automatic test_geometry_extremes();
    tx_gap_max = 0;
    rx_mode    = RX_SLOW;
    set_geometry(1, 1, 1);
    send_cmd(write_cmd(0, 8));                        // covers both one-pixel pages
    send_cmd(screen_cmd(CMD_SET, 1, $urandom(), BPP_DEPTH));
    send_cmd(write_cmd(4, 4));
    set_geometry(4096, 4096, 8192);
    send_cmd(write_cmd(0, COUNT_MAX));                // whole store
    send_cmd(screen_cmd(CMD_PAN, 8191, 0, $urandom()));
    send_cmd(write_cmd((64'd1 << 27) + 4095 * 32768 + 16380, 8));  // last visible pixel
    set_geometry(640, 480, 1024);
    send_cmd(write_cmd(2500, 2000));                  // runs past the visible width
    send_cmd(write_cmd(2560, 1536));                  // entirely off screen
  endtask

  // A zero register empties every rectangle; a zero row count refuses set/pan.
  task automatic test_empty_geometry();
    tx_gap_max = 10;
    rx_mode    = RX_FREE;
    set_geometry(16, 0, 16);
    send_cmd(screen_cmd(CMD_SET, 0, $urandom(), 0));
    send_cmd(write_cmd(0, 16));
    set_geometry(0, 10, 16);
    send_cmd(screen_cmd(CMD_PAN, 0, 0, $urandom()));
    send_cmd(write_cmd(0, 64));
    set_geometry(16, 10, 0);
    send_cmd(write_cmd(0, 16));
    send_cmd(screen_cmd(CMD_SET, 5, $urandom(), BPP_DEPTH));
  endtask

  // Random geometries, each with its own pacing on both sides; even rounds use
  // small screens so that rows and pages are crossed often.
  task automatic test_random_traffic();
    int unsigned h, v, p;
    for (int round = 0; round < 6; round++) begin
      if (round % 2 == 0) begin
        h = $urandom_range(1, 64);
        v = $urandom_range(1, 24);
        p = h + $urandom_range(0, 40);
      end else begin
        h = $urandom_range(1, 4096);
        v = $urandom_range(1, 4096);
        p = $urandom_range(h, 8192);
      end
      set_geometry(h, v, p);
      case (round)
        0: begin tx_gap_max = 0;  rx_mode = RX_FREE;   end  // back to back, no stalls
        1: begin tx_gap_max = 3;  rx_mode = RX_CHOPPY; end
        2: begin tx_gap_max = 45; rx_mode = RX_FREE;   end
        3: begin tx_gap_max = 10; rx_mode = RX_SLOW;   end
        4: begin tx_gap_max = 0;  rx_mode = RX_SLOW;   end
        default: begin tx_gap_max = 60; rx_mode = RX_CHOPPY; end
      endcase
      repeat (25) send_cmd(rand_item());
    end
  endtask

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------
  initial begin
    rst_ni           = 1'b0;
    cfg_we_i         = 1'b0;
    cfg_index_i      = CFG_H_RES;
    cfg_data_i       = '0;
    in_valid_i       = 1'b0;
    cmd_i            = CMD_WRITE;
    byte_offset_i    = '0;
    byte_count_i     = '0;
    y_offset_i       = '0;
    x_offset_i       = '0;
    bits_per_pixel_i = '0;
    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    test_reset_defaults();
    test_geometry_extremes();
    test_empty_geometry();
    test_random_traffic();
    settle();

    if (mismatches == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
